// ===== rtl/core/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // One message word on its way from the front end to the compression engine.
   typedef struct packed {
      logic [31:0] word;
      logic        last_blk;
   } qword_type;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int MD5_QUEUE_DEPTH = 4;

   localparam logic [31:0] MD5_IV_A = 32'h67452301;
   localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
   localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
   localparam logic [31:0] MD5_IV_D = 32'h10325476;

   localparam logic [7:0] MD5_PAD_BYTE = 8'h80;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_rot(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word used by each round; the schedule depends on the round group and on i modulo 16.
   function automatic logic [3:0] md5_msg_index(input logic [5:0] i);
      logic [3:0] l;
      logic [3:0] g;
      l = i[3:0];
      case (i[5:4])
         2'd0:    g = l;
         2'd1:    g = 4'(l * 4'd5 + 4'd1);
         2'd2:    g = 4'(l * 4'd3 + 4'd5);
         2'd3:    g = 4'(l * 4'd7);
         default: g = l;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

endpackage

// ===== rtl/core/md5_front.sv =====
// ----------------------------------------------------------------------------
// MD5 front end
// Packs message bytes into little-endian words, keeps the byte count and
// generates the padding and length words when a message is finished.
// ----------------------------------------------------------------------------
module md5_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  md5_pkg::req_type     req_data,
   output logic                 q_push,
   output md5_pkg::qword_type   q_word,
   input  logic                 q_full
);
   import md5_pkg::*;

   logic [63:0] total_ff, total_in;
   logic [31:0] part_ff, part_in;
   logic        pad_ff, pad_in;
   logic        first_ff, first_in;
   logic        extra_ff, extra_in;
   logic [3:0]  wpos_ff, wpos_in;

   logic        accept;
   logic [1:0]  lane;
   logic [31:0] pad_word;

   assign lane     = total_ff[1:0];
   assign req_full = pad_ff | q_full;
   assign accept   = req_push & ~req_full;

   // First padding word: message bytes below the current lane, then the marker.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (2'(j) < lane) begin
            pad_word[8*j +: 8] = part_ff[8*j +: 8];
         end else if (2'(j) == lane) begin
            pad_word[8*j +: 8] = MD5_PAD_BYTE;
         end else begin
            pad_word[8*j +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      part_in  = part_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      extra_in = extra_ff;
      wpos_in  = wpos_ff;
      q_push   = 1'b0;
      q_word   = '{word: 32'h0, last_blk: 1'b0};

      if (accept) begin
         if (req_data.op == OP_DATA) begin
            part_in[8*lane +: 8] = req_data.data_byte;
            total_in = total_ff + 64'd1;
            if (lane == 2'd3) begin
               q_push = 1'b1;
               q_word = '{word: {req_data.data_byte, part_ff[23:0]}, last_blk: 1'b0};
            end
         end else begin
            pad_in   = 1'b1;
            first_in = 1'b1;
            wpos_in  = total_ff[5:2];
            // Fewer than eight bytes left: the length goes into an extra block.
            extra_in = (total_ff[5:3] == 3'b111);
         end
      end else if (pad_ff && !q_full) begin
         q_push   = 1'b1;
         first_in = 1'b0;
         wpos_in  = wpos_ff + 4'd1;
         if (first_ff) begin
            q_word.word = pad_word;
         end else if (!extra_ff && wpos_ff == 4'd14) begin
            q_word.word = {total_ff[28:0], 3'b000};
         end else if (!extra_ff && wpos_ff == 4'd15) begin
            q_word.word = total_ff[60:29];
         end
         if (wpos_ff == 4'd15) begin
            if (extra_ff) begin
               extra_in = 1'b0;
            end else begin
               q_word.last_blk = 1'b1;
               pad_in   = 1'b0;
               total_in = 64'h0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 64'h0;
         pad_ff   <= 1'b0;
         first_ff <= 1'b0;
         extra_ff <= 1'b0;
         wpos_ff  <= 4'h0;
      end else begin
         total_ff <= total_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         extra_ff <= extra_in;
         wpos_ff  <= wpos_in;
      end
      part_ff <= part_in;
   end

endmodule

// ===== rtl/core/md5_queue.sv =====
// ----------------------------------------------------------------------------
// MD5 word queue
// Short first-in first-out buffer of message words between the front end
// and the compression engine.
// ----------------------------------------------------------------------------
module md5_queue #(
   parameter int Depth = md5_pkg::MD5_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  md5_pkg::qword_type   push_data,
   output logic                 full,
   input  logic                 pop,
   output md5_pkg::qword_type   pop_data,
   output logic                 empty
);
   import md5_pkg::*;

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   qword_type        slot_ff [Depth];
   logic [IdxW-1:0]  wr_ff, wr_in;
   logic [IdxW-1:0]  rd_ff, rd_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == IdxW'(Depth - 1)) ? '0 : wr_ff + IdxW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == IdxW'(Depth - 1)) ? '0 : rd_ff + IdxW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("word queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("word pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("word popped from an empty queue");

endmodule

// ===== rtl/core/md5_back.sv =====
// ----------------------------------------------------------------------------
// MD5 compression engine
// Collects sixteen words into the block buffer, runs the 64 rounds one per
// cycle, updates the chaining words and hands out the digest.
// ----------------------------------------------------------------------------
module md5_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  md5_pkg::qword_type   q_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output md5_pkg::rsp_type     rsp_data
);
   import md5_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  wcnt_ff, wcnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        last_blk_ff, last_blk_in;
   logic [1:0]  emit_ff, emit_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] km_ff, km_in;
   logic [31:0] blk_ff [16];

   logic [5:0]  rd_rnd;
   logic [31:0] rd_word;
   logic [31:0] f;
   logic [31:0] b_new;
   logic        out_load;

   // The message word and constant for the next round are summed into a register ahead of it.
   assign rd_rnd  = (state_ff == ST_PREP) ? 6'd0 : rnd_ff + 6'd1;
   assign rd_word = blk_ff[md5_msg_index(rd_rnd)];

   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1:    f = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2:    f = b_ff ^ c_ff ^ d_ff;
         2'd3:    f = c_ff ^ (b_ff | ~d_ff);
         default: f = 32'h0;
      endcase
   end

   assign b_new = b_ff + md5_rotl(a_ff + f + km_ff, md5_rot(rnd_ff));

   assign out_load  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);
   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in    = state_ff;
      wcnt_in     = wcnt_ff;
      rnd_in      = rnd_ff;
      last_blk_in = last_blk_ff;
      emit_in     = emit_ff;
      out_in      = out_ff;
      chain_in    = chain_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      km_in       = km_ff;
      q_pop       = 1'b0;

      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            q_pop = ~q_empty;
            if (!q_empty) begin
               wcnt_in = wcnt_ff + 4'd1;
               if (wcnt_ff == 4'd15) begin
                  last_blk_in = q_data.last_blk;
                  state_in    = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            km_in    = md5_k(rd_rnd) + rd_word;
            rnd_in   = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            a_in   = d_ff;
            b_in   = b_new;
            c_in   = b_ff;
            d_in   = c_ff;
            km_in  = md5_k(rd_rnd) + rd_word;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            emit_in     = 2'd0;
            state_in    = last_blk_ff ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (out_load) begin
               out_in       = '{digest_word: chain_ff[emit_ff], word_index: emit_ff,
                                last_word: (emit_ff == 2'd3)};
               out_valid_in = 1'b1;
               emit_in      = emit_ff + 2'd1;
               if (emit_ff == 2'd3) begin
                  chain_in[0] = MD5_IV_A;
                  chain_in[1] = MD5_IV_B;
                  chain_in[2] = MD5_IV_C;
                  chain_in[3] = MD5_IV_D;
                  state_in    = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         wcnt_ff      <= 4'h0;
         rnd_ff       <= 6'h0;
         last_blk_ff  <= 1'b0;
         emit_ff      <= 2'h0;
         out_valid_ff <= 1'b0;
         chain_ff[0]  <= MD5_IV_A;
         chain_ff[1]  <= MD5_IV_B;
         chain_ff[2]  <= MD5_IV_C;
         chain_ff[3]  <= MD5_IV_D;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         rnd_ff       <= rnd_in;
         last_blk_ff  <= last_blk_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
      out_ff <= out_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      km_ff  <= km_in;
      if (state_ff == ST_LOAD && !q_empty) begin
         blk_ff[wcnt_ff] <= q_data.word;
      end
   end

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (rnd_ff == 6'd0))
      else $error("round counter left running outside the round state");

   a_iv_restored: assert property (@(posedge clock) disable iff (reset)
      (out_load && emit_ff == 2'd3) |=>
         (state_ff == ST_LOAD && chain_ff[0] == MD5_IV_A && chain_ff[3] == MD5_IV_D))
      else $error("chaining words not restored after the digest");

   // An earlier digest beat may still be waiting here; only a new one is wrong.
   a_mid_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && !last_blk_ff) |=> (state_ff == ST_LOAD && !$rose(out_valid_ff)))
      else $error("digest produced for an inner block");

endmodule

// ===== rtl/core/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-serial MD5 engine: a front end packs bytes and pads the message, a
// word queue decouples it from the round engine, which emits the digest.
// ----------------------------------------------------------------------------
// Usage: push one item per beat on the req_ channel while req_full is low.
// A data item carries one message byte; a finish item closes the message.
// The digest then appears on the rsp_ channel as four beats, word A first,
// last_word set on word D, and the engine is ready for the next message.
// Bytes are taken at one per cycle until the word queue fills, but not while
// padding is under way. Once its last word is loaded, a block holds the round
// engine through a prepare step, the 64 rounds and a step that adds the
// chaining words; the four-word queue holds only 16 bytes meanwhile, so on long
// messages the front end stalls. After a finish the front end emits padding
// words at one per cycle while the queue has room; when the length spills
// over, an extra block of padding is compressed before the digest appears.
// While rsp_pop stays low the digest is held in the output register and the
// engine waits; the front end keeps taking bytes until the queue is full.
// Reset, synchronous and active high, empties the queue, clears the byte
// count and loads the initial vector; no clearing pass is needed.
// ----------------------------------------------------------------------------
module md5_message_digest #(
   parameter int QueueDepth = md5_pkg::MD5_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  md5_pkg::req_type   req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output md5_pkg::rsp_type   rsp_data
);
   import md5_pkg::*;

   logic      fq_push, fq_full, bq_pop, bq_empty;
   qword_type fq_word, bq_word;

   md5_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (fq_push),
      .q_word   (fq_word),
      .q_full   (fq_full)
   );

   md5_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_word),
      .full      (fq_full),
      .pop       (bq_pop),
      .pop_data  (bq_word),
      .empty     (bq_empty)
   );

   md5_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (bq_empty),
      .q_pop     (bq_pop),
      .q_data    (bq_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/md5_message_digest_test.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Feeds byte messages, first from a short table and then at random, into the
// digest engine with random gaps and back-pressure, and compares each digest
// beat with a bit-accurate MD5 predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module md5_message_digest_test;
   import md5_pkg::*;

   localparam logic [127:0] EMPTY_MESSAGE_DIGEST =
      {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};

   typedef struct packed {
      req_type      item;
      logic         typed;
      logic [127:0] digest;
   } directed_step_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   // Predictor state: chaining words, block buffer and message byte count.
   logic [31:0] chain_words [4];
   logic [31:0] block_words [16];
   logic [63:0] byte_count;

   logic [31:0] round_const [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   int unsigned round_shift [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   directed_step_type directed_steps [15] = '{
      '{'{OP_FINISH, 8'hff}, 1'b1, EMPTY_MESSAGE_DIGEST},
      '{'{OP_FINISH, 8'h00}, 1'b1, EMPTY_MESSAGE_DIGEST},
      '{'{OP_DATA,   8'h61}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h62}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h63}, 1'b0, 128'h0},
      '{'{OP_FINISH, 8'h00}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h00}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'hff}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h80}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h7f}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h55}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'haa}, 1'b0, 128'h0},
      '{'{OP_FINISH, 8'hff}, 1'b0, 128'h0},
      '{'{OP_DATA,   8'h00}, 1'b0, 128'h0},
      '{'{OP_FINISH, 8'h5a}, 1'b0, 128'h0}
   };

   rsp_type     digest_beats_due [$];
   int          fault_count  = 0;
   int          pop_stall    = 0;
   bit          steady_phase = 1'b0;

   md5_message_digest u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("md5_message_digest: mismatch");
      $finish;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void restart_digest();
      chain_words[0] = MD5_IV_A;
      chain_words[1] = MD5_IV_B;
      chain_words[2] = MD5_IV_C;
      chain_words[3] = MD5_IV_D;
      byte_count     = '0;
   endfunction

   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] v);
      block_words[pos[5:2]][8 * pos[1:0] +: 8] = v;
   endfunction

   function automatic void compress_block();
      logic [31:0] a, b, c, d, f, t;
      int unsigned g;
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = d ^ (b & (c ^ d));
               g = i;
            end
            1: begin
               f = c ^ (d & (b ^ c));
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotate_left(a + f + round_const[i] + block_words[g],
                             round_shift[(i / 16) * 4 + i % 4]);
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endfunction

   // Returns 1 when the item closes a message; the digest is {A, B, C, D}.
   function automatic bit absorb_item(input req_type item, output logic [127:0] digest);
      logic [5:0]  offset;
      logic [63:0] bit_length;
      offset = byte_count[5:0];
      digest = '0;
      if (item.op == OP_DATA) begin
         place_byte(offset, item.data_byte);
         byte_count++;
         if (offset == 6'd63) compress_block();
         return 1'b0;
      end
      place_byte(offset, MD5_PAD_BYTE);
      for (int p = int'(offset) + 1; p < 64; p++) place_byte(6'(p), 8'h00);
      // No room left for the length field, so it goes into an extra block.
      if (offset >= 6'd56) begin
         compress_block();
         foreach (block_words[w]) block_words[w] = '0;
      end
      bit_length      = byte_count << 3;
      block_words[14] = bit_length[31:0];
      block_words[15] = bit_length[63:32];
      compress_block();
      digest = {chain_words[0], chain_words[1], chain_words[2], chain_words[3]};
      restart_digest();
      return 1'b1;
   endfunction

   function automatic void queue_digest(input logic [127:0] digest);
      rsp_type beat;
      for (int k = 0; k < 4; k++) begin
         beat.digest_word = digest[127 - 32 * k -: 32];
         beat.word_index  = 2'(k);
         beat.last_word   = (k == 3);
         digest_beats_due.push_back(beat);
      end
   endfunction

   function automatic void report_fault(input string text);
      fault_count++;
      if (fault_count <= 10) $display("%s", text);
   endfunction

   function automatic void check_digest_beat(input rsp_type got);
      rsp_type want;
      if (digest_beats_due.size() == 0) begin
         report_fault($sformatf("digest beat %h/%0d/%0b arrived with none due",
                                got.digest_word, got.word_index, got.last_word));
         return;
      end
      want = digest_beats_due.pop_front();
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word)
         report_fault($sformatf("digest beat: expected %h/%0d/%0b, got %h/%0d/%0b",
                                want.digest_word, want.word_index, want.last_word,
                                got.digest_word, got.word_index, got.last_word));
   endfunction

   // Mostly short gaps, now and then a long one, none at all in a steady phase.
   function automatic int pick_gap();
      int r;
      if (steady_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic int pick_length();
      int boundary [8] = '{0, 1, 55, 56, 57, 63, 64, 65};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 8);
         4, 5, 6:    return boundary[$urandom_range(0, 7)];
         7, 8:       return $urandom_range(9, 70);
         default:    return $urandom_range(100, 140);
      endcase
   endfunction

   task automatic send_beat(input req_type item, input logic typed,
                            input logic [127:0] typed_digest);
      logic [127:0] predicted;
      int           gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (absorb_item(item, predicted)) queue_digest(typed ? typed_digest : predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_digest_beat(rsp_data);
         if (steady_phase) begin
            pop_stall = 0;
            rsp_pop <= 1'b1;
         end else if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            pop_stall = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 100)
                                                    : $urandom_range(0, 2);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      req_type item;
      int      length;
      int      random_beats;
      restart_digest();
      random_beats = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[n])
         send_beat(directed_steps[n].item, directed_steps[n].typed, directed_steps[n].digest);

      while (random_beats < 185) begin
         steady_phase = ($urandom_range(0, 3) == 0);
         length = pick_length();
         repeat (length) begin
            item.op        = OP_DATA;
            item.data_byte = 8'($urandom_range(0, 255));
            send_beat(item, 1'b0, '0);
            random_beats++;
         end
         item.op        = OP_FINISH;
         item.data_byte = 8'($urandom_range(0, 255));
         send_beat(item, 1'b0, '0);
         random_beats++;
      end
      req_push <= 1'b0;
      steady_phase = 1'b0;

      while (digest_beats_due.size() != 0) @(posedge clock);
      // Allow time for any stray beat that the engine might still produce.
      repeat (250) @(posedge clock);
      if (fault_count == 0)
         $display("md5_message_digest: match");
      else
         $display("md5_message_digest: mismatch");
      $finish;
   end

endmodule
